@@ sv/ptq_pkg.sv @@
`timescale 1ns / 1ps
package ptq_pkg;
	localparam int MODE_W = 4;
	localparam int SLOT_ID_W = 4;
	localparam int REP_W = 16;
	localparam int IO_TIME_W = 48;

	localparam logic [MODE_W-1:0] MODE_CREATE  = 4'd0;
	localparam logic [MODE_W-1:0] MODE_PAUSE   = 4'd1;
	localparam logic [MODE_W-1:0] MODE_RESUME  = 4'd2;
	localparam logic [MODE_W-1:0] MODE_RESET   = 4'd3;
	localparam logic [MODE_W-1:0] MODE_CANCEL  = 4'd4;
	localparam logic [MODE_W-1:0] MODE_ADVANCE = 4'd5;
	localparam logic [MODE_W-1:0] MODE_SETCLK  = 4'd6;
	localparam logic [MODE_W-1:0] MODE_CLEAR   = 4'd7;
	localparam logic [MODE_W-1:0] MODE_QUERY   = 4'd8;

	typedef enum logic [1:0] {
		ST_FREE   = 2'd0,
		ST_ACTIVE = 2'd1,
		ST_PAUSED = 2'd2
	} slot_st_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the incoming item
		logic clk_upd;   // apply advance or set clock
		logic cmd_exec;  // perform a slot command and form the reply
		logic set_last;  // mark the held event as the last of its command
		logic scan_clr;  // start a due search
		logic scan_step; // examine one slot
		logic fire;      // fire the best slot and emit an event
		logic none_rep;  // emit the reply of a clock change with no firing
		logic set_more;  // flag more_pending on the held event
		logic out_take;  // result register has been taken
	} ptq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_clock;  // item is advance or set clock
		logic scan_done; // last slot examined
		logic found;     // a due slot has been found
		logic out_full;  // result register holds an item
	} ptq_sts_t;
endpackage

@@ sv/ptq_ctrl.sv @@
`timescale 1ns / 1ps
module ptq_ctrl #(
	parameter int EV_W = 7,
	parameter int MAX_EVENTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  ptq_pkg::ptq_sts_t sts,
	output ptq_pkg::ptq_cmd_t cmd,
	output logic             last_flag
);
	import ptq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_EXEC, S_SCAN, S_FIRE, S_CHKSCAN, S_DONE
	} state_t;

	state_t state_q;
	logic [EV_W-1:0] events_q;
	logic held_q; // an event waits in the result register with last undecided
	logic out_free;

	// A held event is not offered until the following search has decided last.
	assign out_valid = sts.out_full && !held_q;
	assign out_free = !sts.out_full || (out_valid && !out_stall);

	always_comb begin
		cmd = '0;
		cmd.out_take = out_valid && !out_stall;
		in_stall = !(state_q == S_IDLE && out_free);
		last_flag = 1'b0;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid && out_free;
			S_DECODE: begin
				if (sts.is_clock) begin
					cmd.clk_upd = 1'b1;
					cmd.scan_clr = 1'b1;
				end
			end
			S_EXEC: if (out_free) begin
				cmd.cmd_exec = 1'b1;
				last_flag = 1'b1;
			end
			S_SCAN, S_CHKSCAN: cmd.scan_step = 1'b1;
			S_FIRE: begin
				if (held_q) begin
					if (!sts.found) cmd.set_last = 1'b1;
				end else if (out_free) begin
					if (sts.found) begin
						cmd.fire = 1'b1;
						cmd.scan_clr = 1'b1;
					end else begin
						cmd.none_rep = 1'b1;
						last_flag = 1'b1;
					end
				end
			end
			S_DONE: begin
				cmd.set_last = 1'b1;
				cmd.set_more = sts.found;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			events_q <= '0;
			held_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_DECODE;
				S_DECODE: begin
					events_q <= '0;
					held_q <= 1'b0;
					state_q <= sts.is_clock ? S_SCAN : S_EXEC;
				end
				S_EXEC: if (out_free) state_q <= S_IDLE;
				S_SCAN: if (sts.scan_done) state_q <= S_FIRE;
				S_FIRE: begin
					if (held_q) begin
						// The held event is released, as a middle or as the final one.
						held_q <= 1'b0;
						if (!sts.found) state_q <= S_IDLE;
					end else if (out_free) begin
						if (sts.found) begin
							held_q <= 1'b1;
							events_q <= events_q + 1'b1;
							state_q <= (events_q + 1'b1 == EV_W'(MAX_EVENTS)) ?
								S_CHKSCAN : S_SCAN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_CHKSCAN: if (sts.scan_done) state_q <= S_DONE;
				S_DONE: begin
					held_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ sv/ptq_dp.sv @@
`timescale 1ns / 1ps
module ptq_dp #(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_BITS = 48,
	parameter int IDX_W = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  ptq_pkg::ptq_cmd_t cmd,
	output ptq_pkg::ptq_sts_t sts,
	input  logic last_flag,
	input  logic [ptq_pkg::MODE_W-1:0]    mode,
	input  logic [ptq_pkg::SLOT_ID_W-1:0] slot_id,
	input  logic [ptq_pkg::IO_TIME_W-1:0] period,
	input  logic [ptq_pkg::REP_W-1:0]     repeat_count,
	input  logic [ptq_pkg::IO_TIME_W-1:0] time_value,
	output logic is_expiry,
	output logic ok,
	output logic [ptq_pkg::SLOT_ID_W-1:0] timer_slot,
	output logic [1:0] slot_status,
	output logic [ptq_pkg::IO_TIME_W-1:0] time_left,
	output logic [ptq_pkg::REP_W-1:0] repeats_left,
	output logic final_fire,
	output logic more_pending,
	output logic last
);
	import ptq_pkg::*;

	localparam logic [TIME_BITS-1:0] TMAX = '1;

	slot_st_t st_q [TIMER_SLOTS];
	logic [TIME_BITS-1:0] per_q [TIMER_SLOTS];
	logic [TIME_BITS-1:0] dl_q [TIMER_SLOTS];
	logic [REP_W-1:0] rep_q [TIMER_SLOTS];
	logic [IDX_W-1:0] rank_q [TIMER_SLOTS];

	logic [MODE_W-1:0] mode_q;
	logic [SLOT_ID_W-1:0] sid_q;
	logic [TIME_BITS-1:0] per_in_q, tv_q, clock_q;
	logic [REP_W-1:0] reps_in_q;

	logic [IDX_W-1:0] scan_q, best_q;
	logic found_q;
	logic out_full_q;

	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
			input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
	endfunction

	wire in_range = {{(32-SLOT_ID_W){1'b0}}, sid_q} < TIMER_SLOTS;
	wire [IDX_W-1:0] s = in_range ? IDX_W'(sid_q) : '0;
	slot_st_t cur;
	assign cur = st_q[s];

	// Active count excluding one slot.
	function automatic logic [IDX_W-1:0] n_active(input logic [IDX_W-1:0] ex);
		logic [IDX_W:0] n;
		n = '0;
		for (int t = 0; t < TIMER_SLOTS; t++)
			if (IDX_W'(t) != ex && st_q[t] == ST_ACTIVE) n = n + 1'b1;
		return n[IDX_W-1:0];
	endfunction

	wire [IDX_W-1:0] scan_i = scan_q;
	wire cand = st_q[scan_i] == ST_ACTIVE && dl_q[scan_i] <= clock_q;
	wire better = !found_q || dl_q[scan_i] < dl_q[best_q] ||
		(dl_q[scan_i] == dl_q[best_q] && rank_q[scan_i] < rank_q[best_q]);

	wire [TIME_BITS-1:0] left_act = dl_q[s] > clock_q ? dl_q[s] - clock_q : '0;
	wire [REP_W-1:0] b_rep_dec = rep_q[best_q] - 1'b1;
	wire b_fin = rep_q[best_q] == REP_W'(1);

	assign sts.is_clock = mode_q == MODE_ADVANCE || mode_q == MODE_SETCLK;
	assign sts.scan_done = scan_q == IDX_W'(TIMER_SLOTS - 1);
	assign sts.found = found_q;
	assign sts.out_full = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TIMER_SLOTS; t++) st_q[t] <= ST_FREE;
			clock_q <= '0;
			out_full_q <= 1'b0;
			found_q <= 1'b0;
			scan_q <= '0;
		end else begin
			if (cmd.out_take) out_full_q <= 1'b0;
			if (cmd.load) begin
				mode_q <= mode;
				sid_q <= slot_id;
				per_in_q <= TIME_BITS'(period);
				reps_in_q <= repeat_count;
				tv_q <= TIME_BITS'(time_value);
			end
			if (cmd.clk_upd)
				clock_q <= (mode_q == MODE_ADVANCE) ? sat_add(clock_q, tv_q) : tv_q;
			if (cmd.scan_clr) begin
				scan_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (cand && better) begin
					best_q <= scan_i;
					found_q <= 1'b1;
				end
				if (!sts.scan_done) scan_q <= scan_q + 1'b1;
			end
			// The held event learns at the end of the following search whether it is last.
			if (cmd.set_more) more_pending <= 1'b1;
			if (cmd.set_last) last <= 1'b1;
			if (cmd.fire) begin
				for (int t = 0; t < TIMER_SLOTS; t++)
					if (IDX_W'(t) != best_q && st_q[t] == ST_ACTIVE && rank_q[t] > rank_q[best_q])
						rank_q[t] <= rank_q[t] - 1'b1;
				if (rep_q[best_q] != '0) rep_q[best_q] <= b_rep_dec;
				if (b_fin) st_q[best_q] <= ST_FREE;
				else begin
					dl_q[best_q] <= sat_add(dl_q[best_q], per_q[best_q]);
					rank_q[best_q] <= n_active(best_q);
				end
				out_full_q <= 1'b1;
				is_expiry <= 1'b1;
				ok <= 1'b1;
				timer_slot <= SLOT_ID_W'(best_q);
				slot_status <= b_fin ? ST_FREE : ST_ACTIVE;
				time_left <= '0;
				repeats_left <= (rep_q[best_q] != '0) ? b_rep_dec : '0;
				final_fire <= b_fin;
				more_pending <= 1'b0;
				last <= 1'b0;
			end
			if (cmd.none_rep) begin
				out_full_q <= 1'b1;
				{is_expiry, timer_slot, slot_status, time_left, repeats_left} <= '0;
				{final_fire, more_pending} <= '0;
				ok <= 1'b1;
				last <= 1'b1;
			end
			if (cmd.cmd_exec) begin
				logic rok;
				slot_st_t nst;
				logic [REP_W-1:0] nrep;
				logic [TIME_BITS-1:0] lft;
				rok = 1'b0;
				nst = cur;
				nrep = rep_q[s];
				lft = '0;
				if (mode_q == MODE_CLEAR) begin
					for (int t = 0; t < TIMER_SLOTS; t++) st_q[t] <= ST_FREE;
					rok = 1'b1;
				end else if (mode_q <= MODE_QUERY && in_range) begin
					unique case (mode_q)
						MODE_CREATE: if (cur == ST_FREE && per_in_q != '0) begin
							per_q[s] <= per_in_q;
							rep_q[s] <= reps_in_q;
							nrep = reps_in_q;
							dl_q[s] <= sat_add(clock_q, per_in_q);
							rank_q[s] <= n_active(s);
							nst = ST_ACTIVE;
							rok = 1'b1;
						end
						MODE_PAUSE: if (cur == ST_ACTIVE) begin
							for (int t = 0; t < TIMER_SLOTS; t++)
								if (IDX_W'(t) != s && st_q[t] == ST_ACTIVE && rank_q[t] > rank_q[s])
									rank_q[t] <= rank_q[t] - 1'b1;
							dl_q[s] <= left_act;
							nst = ST_PAUSED;
							rok = 1'b1;
						end
						MODE_RESUME: if (cur == ST_PAUSED) begin
							dl_q[s] <= sat_add(clock_q, dl_q[s]);
							rank_q[s] <= n_active(s);
							nst = ST_ACTIVE;
							rok = 1'b1;
						end
						MODE_RESET: if (cur == ST_ACTIVE) begin
							for (int t = 0; t < TIMER_SLOTS; t++)
								if (IDX_W'(t) != s && st_q[t] == ST_ACTIVE && rank_q[t] > rank_q[s])
									rank_q[t] <= rank_q[t] - 1'b1;
							dl_q[s] <= sat_add(clock_q, per_q[s]);
							rank_q[s] <= n_active(s);
							rok = 1'b1;
						end
						MODE_CANCEL: if (cur != ST_FREE) begin
							if (cur == ST_ACTIVE)
								for (int t = 0; t < TIMER_SLOTS; t++)
									if (IDX_W'(t) != s && st_q[t] == ST_ACTIVE &&
											rank_q[t] > rank_q[s])
										rank_q[t] <= rank_q[t] - 1'b1;
							nst = ST_FREE;
							rok = 1'b1;
						end
						default: begin
							rok = 1'b1;
							if (cur == ST_ACTIVE) lft = left_act;
							else if (cur == ST_PAUSED) lft = dl_q[s];
						end
					endcase
					st_q[s] <= nst;
				end
				out_full_q <= 1'b1;
				is_expiry <= 1'b0;
				ok <= rok;
				final_fire <= 1'b0;
				more_pending <= 1'b0;
				last <= last_flag;
				time_left <= IO_TIME_W'(lft);
				if (mode_q <= MODE_QUERY && mode_q != MODE_CLEAR && in_range) begin
					timer_slot <= sid_q;
					slot_status <= nst;
					repeats_left <= (nst != ST_FREE) ? nrep : '0;
				end else begin
					timer_slot <= (mode_q <= MODE_QUERY && mode_q != MODE_CLEAR) ? sid_q : '0;
					slot_status <= ST_FREE;
					repeats_left <= '0;
				end
			end
		end
	end
endmodule

@@ sv/periodic_timer_queue_core.sv @@
`timescale 1ns / 1ps
// Periodic timer queue: a table of TIMER_SLOTS timer slots and a running clock in
// 1/65536 units. Each input item is one command; slot commands give a single
// reply item. Advance and set clock search the table for the earliest due timer,
// one slot a cycle, and the clock change ends with one further sweep when
// MAX_EVENTS items have been given. An expiry item is held back until the
// following search has decided whether it is the last one. The search loop over
// the slot table sets the rate. Items are emitted in deadline order, ties in
// queue order, and the last item of a command carries last.
module periodic_timer_queue_core #(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_BITS = 48,
	parameter int MAX_EVENTS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [ptq_pkg::MODE_W-1:0]    mode,
	input  logic [ptq_pkg::SLOT_ID_W-1:0] slot_id,
	input  logic [ptq_pkg::IO_TIME_W-1:0] period,
	input  logic [ptq_pkg::REP_W-1:0]     repeat_count,
	input  logic [ptq_pkg::IO_TIME_W-1:0] time_value,
	output logic out_valid,
	input  logic out_stall,
	output logic is_expiry,
	output logic ok,
	output logic [ptq_pkg::SLOT_ID_W-1:0] timer_slot,
	output logic [1:0] slot_status,
	output logic [ptq_pkg::IO_TIME_W-1:0] time_left,
	output logic [ptq_pkg::REP_W-1:0] repeats_left,
	output logic final_fire,
	output logic more_pending,
	output logic last
);
	import ptq_pkg::*;

	localparam int IDX_W = $clog2(TIMER_SLOTS);
	localparam int EV_W = $clog2(MAX_EVENTS + 1);

	ptq_cmd_t cmd;
	ptq_sts_t sts;
	logic last_flag;

	// The extra sweep after the cap only decides more_pending.
	ptq_ctrl #(.EV_W(EV_W), .MAX_EVENTS(MAX_EVENTS)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd, .last_flag
	);

	ptq_dp #(.TIMER_SLOTS(TIMER_SLOTS), .TIME_BITS(TIME_BITS), .IDX_W(IDX_W)) u_dp (
		.clk, .arst_n, .cmd, .sts, .last_flag,
		.mode, .slot_id, .period, .repeat_count, .time_value,
		.is_expiry, .ok, .timer_slot, .slot_status, .time_left, .repeats_left,
		.final_fire, .more_pending, .last
	);
endmodule

@@ sv/ptq_checker.sv @@
`timescale 1ns / 1ps
module ptq_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic is_expiry,
	input logic ok,
	input logic final_fire,
	input logic time_left_nz
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("item dropped while stalled");
	a_exp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_expiry |-> ok) else $error("expiry without ok");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_fire |-> is_expiry) else $error("final_fire on reply");
	a_left: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_expiry |-> !time_left_nz) else $error("time_left on expiry");
endmodule

bind periodic_timer_queue_core ptq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.is_expiry(is_expiry), .ok(ok), .final_fire(final_fire),
	.time_left_nz(|time_left)
);
